/* hw/rtl/sit_pkg.sv */
// Shared types for the segment intersection test pipeline.
// No dependencies; imported by sit_core and segment_intersection_test.
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

  // Number of coordinate fields packed in one input transfer.
  localparam int unsigned NUM_COORDS = 8;

  // Result byte layout on the master side.
  localparam int unsigned OUT_DATA_W = 8;
  localparam int unsigned OUT_HIT_BIT = 0;
  localparam int unsigned OUT_PAR_BIT = 1;

  // Per-stage load enables from the flow control into the datapath.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } sit_adv_t;

endpackage

`default_nettype wire

/* hw/rtl/sit_core.sv */
// Datapath of the segment intersection test: differences, products,
// cross products, sign/magnitude flags and the final decision, one register stage each.
// Depends on sit_pkg (sit_adv_t).
`timescale 1ns / 1ps
`default_nettype none

module sit_core #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                  clk,
  input  wire sit_pkg::sit_adv_t               adv,
  input  wire signed [COORD_WIDTH-1:0]         px0,
  input  wire signed [COORD_WIDTH-1:0]         py0,
  input  wire signed [COORD_WIDTH-1:0]         px1,
  input  wire signed [COORD_WIDTH-1:0]         py1,
  input  wire signed [COORD_WIDTH-1:0]         qx0,
  input  wire signed [COORD_WIDTH-1:0]         qy0,
  input  wire signed [COORD_WIDTH-1:0]         qx1,
  input  wire signed [COORD_WIDTH-1:0]         qy1,
  output logic                                 intersects,
  output logic                                 parallel,
  output logic                                 det_zero_flag,
  output logic                                 det_neg_flag
);
  import sit_pkg::*;

  localparam int DW = COORD_WIDTH + 1;       // difference width
  localparam int PW = 2 * COORD_WIDTH + 2;   // product width
  localparam int CW = 2 * COORD_WIDTH + 3;   // cross product width

  // stage 1: differences and the parallel-case compares
  logic signed [DW-1:0] a11, a12, a21, a22, b1, b2;
  logic                 vert1, xeq1, ovy1, ovx1;
  // stage 2: products
  logic signed [PW-1:0] p_a11a22, p_a12a21, p_b1a22, p_a12b2, p_a11b2, p_b1a21;
  logic                 vert2, xeq2, ovy2, ovx2;
  // stage 3: cross products
  logic signed [CW-1:0] det, nr, nt;
  logic                 vert3, xeq3, ovy3, ovx3;
  // stage 4: flags
  logic det_zero, det_neg, nr_neg, nr_zero, nt_neg, nt_zero;
  logic nr_le_det, nr_ge_det, nt_le_det, nt_ge_det;
  logic vert4, xeq4, ovy4, ovx4;

  function automatic logic signed [DW-1:0] sub_ext(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b
  );
    return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
  endfunction

  // one-sided overlap: a,b first segment, c,d second
  function automatic logic overlap(
    input logic signed [COORD_WIDTH-1:0] a,
    input logic signed [COORD_WIDTH-1:0] b,
    input logic signed [COORD_WIDTH-1:0] c,
    input logic signed [COORD_WIDTH-1:0] d
  );
    return (a <= c) ? (b >= c) : (d >= a);
  endfunction

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      a11   <= sub_ext(px1, px0);
      a12   <= sub_ext(qx0, qx1);
      a21   <= sub_ext(py1, py0);
      a22   <= sub_ext(qy0, qy1);
      b1    <= sub_ext(qx0, px0);
      b2    <= sub_ext(qy0, py0);
      vert1 <= (px0 == px1);
      xeq1  <= (px0 == qx0);
      ovy1  <= overlap(py0, py1, qy0, qy1);
      ovx1  <= overlap(px0, px1, qx0, qx1);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      p_a11a22 <= a11 * a22;
      p_a12a21 <= a12 * a21;
      p_b1a22  <= b1 * a22;
      p_a12b2  <= a12 * b2;
      p_a11b2  <= a11 * b2;
      p_b1a21  <= b1 * a21;
      vert2    <= vert1;
      xeq2     <= xeq1;
      ovy2     <= ovy1;
      ovx2     <= ovx1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      det   <= $signed({p_a11a22[PW-1], p_a11a22}) - $signed({p_a12a21[PW-1], p_a12a21});
      nr    <= $signed({p_b1a22[PW-1], p_b1a22}) - $signed({p_a12b2[PW-1], p_a12b2});
      nt    <= $signed({p_a11b2[PW-1], p_a11b2}) - $signed({p_b1a21[PW-1], p_b1a21});
      vert3 <= vert2;
      xeq3  <= xeq2;
      ovy3  <= ovy2;
      ovx3  <= ovx2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s4) begin
      det_zero  <= (det == '0);
      det_neg   <= det[CW-1];
      nr_neg    <= nr[CW-1];
      nr_zero   <= (nr == '0);
      nt_neg    <= nt[CW-1];
      nt_zero   <= (nt == '0);
      nr_le_det <= (nr <= det);
      nr_ge_det <= (nr >= det);
      nt_le_det <= (nt <= det);
      nt_ge_det <= (nt >= det);
      vert4     <= vert3;
      xeq4      <= xeq3;
      ovy4      <= ovy3;
      ovx4      <= ovx3;
    end
  end

  // With a negative determinant the range check flips instead of negating.
  logic hit_np, hit_par;
  always_comb begin
    if (det_neg) begin
      hit_np = (nr_neg || nr_zero) && nr_ge_det && (nt_neg || nt_zero) && nt_ge_det;
    end else begin
      hit_np = !nr_neg && nr_le_det && !nt_neg && nt_le_det;
    end
    hit_par = vert4 ? (xeq4 && ovy4) : (nt_zero && ovx4);
  end

  always_ff @(posedge clk) begin
    if (adv.s5) begin
      intersects <= det_zero ? hit_par : hit_np;
      parallel   <= det_zero;
    end
  end

  assign det_zero_flag = det_zero;
  assign det_neg_flag  = det_neg;

endmodule

`default_nettype wire

/* hw/rtl/segment_intersection_test.sv */
// Segment intersection test: five-stage pipeline from input transfer to result valid,
// one item per cycle sustained while m_tready is high (each stage holds one item).
// The six (W+1)x(W+1) products run side by side in stage 2.
// rst (synchronous, active high) clears all stage valid bits; payload is not reset.
// Depends on sit_pkg and sit_core.
`timescale 1ns / 1ps
`default_nettype none

module segment_intersection_test #(
  parameter int COORD_WIDTH = 16
) (
  input  wire                                        clk,
  input  wire                                        rst,
  input  wire                                        s_tvalid,
  output logic                                       s_tready,
  // low to high: first_start_x, first_start_y, first_end_x, first_end_y,
  // second_start_x, second_start_y, second_end_x, second_end_y
  input  wire  [sit_pkg::NUM_COORDS*COORD_WIDTH-1:0] s_tdata,
  output logic                                       m_tvalid,
  input  wire                                        m_tready,
  // low to high: intersects, parallel, six zero bits
  output logic [sit_pkg::OUT_DATA_W-1:0]             m_tdata
);
  import sit_pkg::*;

  logic     v1, v2, v3, v4, v5;
  logic     rdy1, rdy2, rdy3, rdy4, rdy5;
  sit_adv_t adv;
  logic     hit, par, det_zero, det_neg;

  assign rdy5 = !v5 || m_tready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign adv.s1 = rdy1;
  assign adv.s2 = rdy2;
  assign adv.s3 = rdy3;
  assign adv.s4 = rdy4;
  assign adv.s5 = rdy5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  sit_core #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_core (
    .clk          (clk),
    .adv          (adv),
    .px0          (s_tdata[0*COORD_WIDTH +: COORD_WIDTH]),
    .py0          (s_tdata[1*COORD_WIDTH +: COORD_WIDTH]),
    .px1          (s_tdata[2*COORD_WIDTH +: COORD_WIDTH]),
    .py1          (s_tdata[3*COORD_WIDTH +: COORD_WIDTH]),
    .qx0          (s_tdata[4*COORD_WIDTH +: COORD_WIDTH]),
    .qy0          (s_tdata[5*COORD_WIDTH +: COORD_WIDTH]),
    .qx1          (s_tdata[6*COORD_WIDTH +: COORD_WIDTH]),
    .qy1          (s_tdata[7*COORD_WIDTH +: COORD_WIDTH]),
    .intersects   (hit),
    .parallel     (par),
    .det_zero_flag(det_zero),
    .det_neg_flag (det_neg)
  );

  assign s_tready = rdy1;
  assign m_tvalid = v5;

  always_comb begin
    m_tdata              = '0;
    m_tdata[OUT_HIT_BIT] = hit;
    m_tdata[OUT_PAR_BIT] = par;
  end

  // an item in stage 4 moves to the output when the output can take it
  a_stage_advance: assert property (@(posedge clk) disable iff (rst)
    v4 && rdy5 |=> v5)
    else $error("stage 4 item lost on advance");

  // input is blocked only when every stage is occupied
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (v1 && v2 && v3 && v4 && v5))
    else $error("input stalled with a free stage");

  // a zero determinant carries no sign
  a_det_flags: assert property (@(posedge clk) disable iff (rst)
    v4 && det_zero |-> !det_neg)
    else $error("zero determinant flagged negative");

  // a parallel result always follows a zero determinant in stage 4
  a_par_source: assert property (@(posedge clk) disable iff (rst)
    v4 && rdy5 |=> (m_tdata[OUT_PAR_BIT] == $past(det_zero)))
    else $error("parallel flag does not match determinant");

endmodule

`default_nettype wire
